// ===== rtl/rlsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsp_pkg
// Shared types and constants for the radial light splat pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rlsp_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int R2_W    = 20;
   localparam int NUM_W   = 29;
   localparam int QUOT_W  = 8;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   typedef enum logic [1:0] {
      REG_CENTRE_X = 2'd0,
      REG_CENTRE_Y = 2'd1,
      REG_RADIUS   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic       valid;
      logic       in_circle;
      logic [7:0] cov;
      logic [7:0] dst;
      logic [7:0] src;
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/rlsp_div.sv =====
// ----------------------------------------------------------------------------
// rlsp_div
// Pipelined restoring divider, one quotient bit per stage, divisor 2*r2.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rlsp_pkg::NUM_W-1:0]  in_num,
   input  wire logic [rlsp_pkg::R2_W-1:0]   in_r2,
   input  wire rlsp_pkg::side_type          in_side,
   output logic      [rlsp_pkg::QUOT_W-1:0] out_quot,
   output rlsp_pkg::side_type               out_side
);
   import rlsp_pkg::*;

   logic [NUM_W-1:0]  rem_src [QUOT_W];
   logic [QUOT_W-1:0] quot_src [QUOT_W];
   side_type          side_src [QUOT_W];

   logic [NUM_W-1:0]  rem_in [QUOT_W];
   logic [QUOT_W-1:0] quot_in [QUOT_W];
   logic [NUM_W-1:0]  rem_ff [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   side_type          side_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic [NUM_W-1:0] den_shift;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_src[k]  = in_num;
         assign quot_src[k] = '0;
         assign side_src[k] = in_side;
      end else begin : g_next
         assign rem_src[k]  = rem_ff[k-1];
         assign quot_src[k] = quot_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      assign den_shift  = NUM_W'({in_r2, 1'b0}) << (QUOT_W - 1 - k);
      assign take       = rem_src[k] >= den_shift;
      assign rem_in[k]  = take ? (rem_src[k] - den_shift) : rem_src[k];
      assign quot_in[k] = {quot_src[k][QUOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else begin
            side_ff[k] <= side_src[k];
         end
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
      end
   end

   assign out_quot = quot_ff[QUOT_W-1];
   assign out_side = side_ff[QUOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/radial_light_splat_pixel.sv =====
// ----------------------------------------------------------------------------
// radial_light_splat_pixel
// Applies one radial light with quadratic falloff to a stream of pixels.
//
// Pixels enter on start (accepted when start is high and busy is low; busy
// stays low, so a pixel may be presented every cycle). Each transaction
// yields exactly one result on the rsp_ ports, shown for a single cycle
// with rsp_valid once it has passed the offset, square, compare, numerator,
// divider and output registers in turn. Throughput is one
// pixel per cycle: squaring, distance compare, numerator build and an
// eight-stage restoring divider (one quotient bit per stage) form a fully
// pipelined datapath. The receiver cannot stall, so results are never held.
// The user must write light centre and radius through the APB port only
// while no pixel is in flight; the block does not enforce this. Radius
// squared is registered in the cycle after a write. Synchronous reset zeroes
// centre and radius and drops every pixel in flight, with no result for it.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_light_splat_pixel #(
   parameter int MAX_WIDTH  = rlsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rlsp_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [11:0]                 req_pixel_x,
   input  wire logic [11:0]                 req_pixel_y,
   input  wire logic [7:0]                  req_coverage_in,
   input  wire logic [7:0]                  req_dst_pixel,
   input  wire logic [7:0]                  req_src_pixel,
   input  wire logic                        req_roof_covered,
   output logic                             rsp_valid,
   output logic      [7:0]                  rsp_coverage_out,
   output logic      [7:0]                  rsp_pixel_out,
   output logic                             rsp_updated,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [rlsp_pkg::ADDR_W-1:0] paddr,
   input  wire logic [rlsp_pkg::DATA_W-1:0] pwdata,
   output logic      [rlsp_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);
   import rlsp_pkg::*;

   logic signed [13:0] centre_x_ff;
   logic signed [13:0] centre_y_ff;
   logic signed [10:0] radius_ff;
   logic [R2_W-1:0]    r2_ff;
   logic [R2_W-1:0]    r2_in;
   logic               wr_en;
   reg_index_type      wr_index;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign wr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         radius_ff   <= '0;
      end else if (wr_en) begin
         case (wr_index)
            REG_CENTRE_X: begin
               centre_x_ff <= pwdata[13:0];
            end
            REG_CENTRE_Y: begin
               centre_y_ff <= pwdata[13:0];
            end
            REG_RADIUS: begin
               radius_ff <= pwdata[10:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (wr_index)
         REG_CENTRE_X: prdata = DATA_W'({18'b0, centre_x_ff});
         REG_CENTRE_Y: prdata = DATA_W'({18'b0, centre_y_ff});
         REG_RADIUS:   prdata = DATA_W'({21'b0, radius_ff});
         default:      prdata = '0;
      endcase
   end

   assign r2_in = radius_ff[9:0] * radius_ff[9:0];

   always_ff @(posedge clock) begin
      r2_ff <= r2_in;
   end

   // stage 1: offsets from the centre, qualifiers
   side_type           s1_side_in;
   side_type           s1_side_ff;
   logic signed [14:0] dx_in;
   logic signed [14:0] dy_in;
   logic signed [14:0] s1_dx_ff;
   logic signed [14:0] s1_dy_ff;
   logic               rad_pos;

   assign rad_pos = !radius_ff[10] && (radius_ff[9:0] != '0);
   assign dx_in   = $signed({3'b000, req_pixel_x}) - 15'(centre_x_ff);
   assign dy_in   = $signed({3'b000, req_pixel_y}) - 15'(centre_y_ff);

   always_comb begin
      s1_side_in.valid     = start && !busy;
      s1_side_in.in_circle = rad_pos && !req_roof_covered
                             && ({1'b0, req_pixel_x} < 13'(MAX_WIDTH))
                             && ({1'b0, req_pixel_y} < 13'(MAX_HEIGHT));
      s1_side_in.cov       = req_coverage_in;
      s1_side_in.dst       = req_dst_pixel;
      s1_side_in.src       = req_src_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
      end else begin
         s1_side_ff <= s1_side_in;
      end
      s1_dx_ff <= dx_in;
      s1_dy_ff <= dy_in;
   end

   // stage 2: squares
   side_type    s2_side_ff;
   logic [27:0] sqx_in;
   logic [27:0] sqy_in;
   logic [27:0] s2_sqx_ff;
   logic [27:0] s2_sqy_ff;

   assign sqx_in = 28'(s1_dx_ff) * 28'(s1_dx_ff);
   assign sqy_in = 28'(s1_dy_ff) * 28'(s1_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else begin
         s2_side_ff <= s1_side_ff;
      end
      s2_sqx_ff <= sqx_in;
      s2_sqy_ff <= sqy_in;
   end

   // stage 3: distance compare, remaining span
   side_type        s3_side_in;
   side_type        s3_side_ff;
   logic [28:0]     d2_in;
   logic [R2_W-1:0] diff_in;
   logic [R2_W-1:0] s3_diff_ff;

   assign d2_in   = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   assign diff_in = r2_ff - d2_in[R2_W-1:0];

   always_comb begin
      s3_side_in           = s2_side_ff;
      s3_side_in.in_circle = s2_side_ff.in_circle && (d2_in <= 29'(r2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else begin
         s3_side_ff <= s3_side_in;
      end
      s3_diff_ff <= diff_in;
   end

   // stage 4: numerator 510*(r2-d2) + r2
   side_type         s4_side_ff;
   logic [NUM_W-1:0] num_in;
   logic [NUM_W-1:0] s4_num_ff;

   assign num_in = {s3_diff_ff, 9'b0} - NUM_W'({s3_diff_ff, 1'b0}) + NUM_W'(r2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff.valid <= 1'b0;
      end else begin
         s4_side_ff <= s3_side_ff;
      end
      s4_num_ff <= num_in;
   end

   // stages 5 to 12: divide by 2*r2
   logic [QUOT_W-1:0] div_quot;
   side_type          div_side;

   rlsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_num   (s4_num_ff),
      .in_r2    (r2_ff),
      .in_side  (s4_side_ff),
      .out_quot (div_quot),
      .out_side (div_side)
   );

   // output stage: raise coverage where brighter
   logic       lit;
   logic       rsp_valid_ff;
   logic [7:0] rsp_cov_ff;
   logic [7:0] rsp_pix_ff;
   logic       rsp_upd_ff;

   assign lit = div_side.in_circle && (div_quot != '0) && (div_quot > div_side.cov);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_side.valid;
      end
      rsp_cov_ff <= lit ? div_quot : div_side.cov;
      rsp_pix_ff <= lit ? div_side.src : div_side.dst;
      rsp_upd_ff <= lit;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coverage_out = rsp_cov_ff;
   assign rsp_pixel_out    = rsp_pix_ff;
   assign rsp_updated      = rsp_upd_ff;

endmodule

`default_nettype wire
